/* hw/rtl/diet_pkg.sv */
// Package with constants, commands and the hash mixer pieces for the declined item table.
package diet_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [63:0] MixC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixC2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    CmdCheck   = 2'd0,
    CmdDecline = 2'd1,
    CmdSweep   = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

/* hw/rtl/declined_item_expiry_table.sv */
// Declined address and prefix tables with expiry, probed linearly in synchronous memories.
// Steps: an address check/decline passes the hashing states (StMul1a, StMul1b, StMul2a,
// StMul1b, StMixEnd), then a read and a compare state per probed slot, then the output state;
// a prefix adds a second mixer round. Sweep reads and compares each of all TableSize slots,
// then outputs. One item is in work at a time; the next input transfer can come in the
// cycle after the result transfer. Reset clears the used flag memories by a pass over all
// TableSize slots before items are taken.
module declined_item_expiry_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd_i,
  input  logic                kind_i,
  input  logic [63:0]         addr_w0_i,
  input  logic [63:0]         addr_w1_i,
  input  logic [7:0]          prefix_len_i,
  input  logic [63:0]         time_value_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_declined_o,
  output logic                status_o
);
  import diet_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StMul1a, StMul1b, StMul2a, StMixEnd,
    StRead, StCmp, StSwRead, StSwCmp, StOut
  } state_e;

  typedef struct packed {
    logic        used;
    logic [63:0] klo;
    logic [63:0] khi;
    logic [7:0]  plen;
    logic [63:0] exp;
  } ent_t;

  // Memories: per table, a used flag memory and an entry memory holding the payload.
  logic        a_used_mem [TableSize];
  logic        p_used_mem [TableSize];
  ent_t        a_mem [TableSize];
  ent_t        p_mem [TableSize];

  state_e      state_q;
  logic [1:0]  cmd_q;
  logic        kind_q, round_q;
  logic [63:0] w0_q, w1_q, t_q, h_q, plo_q;
  logic [7:0]  plen_q;
  logic [IdxW-1:0] slot_q;
  logic [CntW-1:0] cnt_q;
  logic        decl_q, stat_q;

  logic        rd_used_a, rd_used_p;
  ent_t        rd_a, rd_p;
  logic        we_a, we_p, wu_a, wu_p;
  logic        wuv_a, wuv_p;
  ent_t        wdat;

  // Mixer multiply from 32x32 partial products: the low product is registered in StMul1a or
  // StMul2a, the two cross terms, kept to their low halves, are added in StMul1b.
  logic [63:0] mul_c;
  logic [63:0] mul_lo;
  logic [31:0] mul_mid;
  assign mul_c   = round_q ? MixC2 : MixC1;
  assign mul_lo  = {32'd0, h_q[31:0]} * {32'd0, mul_c[31:0]};
  assign mul_mid = h_q[63:32] * mul_c[31:0] + h_q[31:0] * mul_c[63:32];

  ent_t        cur;
  logic        cur_used, cur_match;
  assign cur      = kind_q ? rd_p : rd_a;
  assign cur_used = kind_q ? rd_used_p : rd_used_a;
  assign cur_match = (cur.klo == w0_q) && (cur.khi == w1_q) &&
                     (!kind_q || cur.plen == plen_q);

  assign in_stall  = (state_q != StIdle);
  assign out_valid = (state_q == StOut);
  assign is_declined_o = decl_q;
  assign status_o      = stat_q;

  always_ff @(posedge clk_i) begin
    rd_used_a <= a_used_mem[slot_q];
    rd_used_p <= p_used_mem[slot_q];
    rd_a      <= a_mem[slot_q];
    rd_p      <= p_mem[slot_q];
    if (wu_a) a_used_mem[slot_q] <= wuv_a;
    if (wu_p) p_used_mem[slot_q] <= wuv_p;
    if (we_a) a_mem[slot_q] <= wdat;
    if (we_p) p_mem[slot_q] <= wdat;
  end

  always_comb begin
    wdat = '{used: 1'b1, klo: w0_q, khi: w1_q, plen: plen_q, exp: t_q};
    we_a = 1'b0; we_p = 1'b0; wu_a = 1'b0; wu_p = 1'b0;
    wuv_a = 1'b0; wuv_p = 1'b0;
    case (state_q)
      StClear: begin
        wu_a = 1'b1; wu_p = 1'b1;
      end
      StCmp: begin
        if (cmd_q == CmdDecline && (!cur_used || cur_match)) begin
          we_a = !kind_q; we_p = kind_q;
          wu_a = !kind_q; wu_p = kind_q;
          wuv_a = 1'b1; wuv_p = 1'b1;
        end
      end
      StSwCmp: begin
        wu_a = 1'b1; wu_p = 1'b1;
        wuv_a = rd_used_a && !(rd_a.exp <= t_q);
        wuv_p = rd_used_p && !(rd_p.exp <= t_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      slot_q  <= '0;
      cnt_q   <= '0;
      decl_q  <= 1'b0;
      stat_q  <= 1'b0;
      round_q <= 1'b0;
    end else begin
      case (state_q)
        StClear: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == IdxW'(TableSize - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid) begin
            cmd_q <= cmd_i; kind_q <= kind_i;
            w0_q <= addr_w0_i; w1_q <= addr_w1_i;
            plen_q <= prefix_len_i; t_q <= time_value_i;
            h_q <= xs33(addr_w0_i ^ addr_w1_i);
            round_q <= 1'b0;
            decl_q <= 1'b0; stat_q <= 1'b0;
            cnt_q <= '0; slot_q <= '0;
            case (cmd_i)
              CmdCheck, CmdDecline: state_q <= StMul1a;
              CmdSweep: state_q <= StSwRead;
              default: state_q <= StOut;
            endcase
          end
        end
        StMul1a: begin
          // Cross terms are added next cycle.
          plo_q <= mul_lo;
          state_q <= StMul1b;
        end
        StMul1b: begin
          h_q <= xs33(plo_q + {mul_mid, 32'd0});
          state_q <= round_q ? StMixEnd : StMul2a;
          round_q <= 1'b1;
        end
        StMul2a: begin
          plo_q <= mul_lo;
          state_q <= StMul1b;
        end
        StMixEnd: begin
          if (kind_q && !cnt_q[0]) begin
            // Second mixer round for prefixes folds in the length.
            h_q <= xs33(h_q ^ {24'd0, plen_q, 32'd0});
            cnt_q <= CntW'(1);
            round_q <= 1'b0;
            state_q <= StMul1a;
          end else begin
            slot_q <= h_q[IdxW-1:0];
            cnt_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StCmp;
        StCmp: begin
          if (!cur_used) begin
            state_q <= StOut;
          end else if (cur_match) begin
            if (cmd_q == CmdCheck) decl_q <= cur.exp > t_q;
            state_q <= StOut;
          end else if (cnt_q == CntW'(TableSize - 1)) begin
            stat_q <= (cmd_q == CmdDecline);
            state_q <= StOut;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            slot_q <= slot_q + 1'b1;
            state_q <= StRead;
          end
        end
        StSwRead: state_q <= StSwCmp;
        StSwCmp: begin
          slot_q <= slot_q + 1'b1;
          state_q <= (slot_q == IdxW'(TableSize - 1)) ? StOut : StSwRead;
        end
        StOut: if (!out_stall) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp && cmd_q == CmdDecline && (!cur_used || cur_match)) |=> !stat_q)
    else $error("decline wrote a slot but reported full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && cmd_q != CmdCheck) |-> !is_declined_o)
    else $error("declined flag on a non-check command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && cmd_q != CmdDecline) |-> !status_o)
    else $error("full status on a non-decline command");
endmodule
